@@ rtl/assert_macros.svh @@
// assertion macros shared by the sorter modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// an implication checked at every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// a condition checked in the cycle after an antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sqs_pkg.sv @@
// shared types and constants of the string sorter
// no dependencies
`default_nettype none
package sqs_pkg;
    localparam int IDX_W = 6;
    localparam int LEN_W = 8;
    localparam int CHR_W = 8;

    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_EQ = 2'd1,
        CMP_GT = 2'd2
    } t_cmp_res;

    typedef struct packed {
        logic       start;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic     done;
        t_cmp_res res;
    } t_cmp_rsp;
endpackage
`default_nettype wire

@@ rtl/sqs_compare.sv @@
// shared string compare unit: walks two stored strings one byte per step
// depends on sqs_pkg and assert_macros.svh; owns the character and length stores
`default_nettype none
`include "assert_macros.svh"
module sqs_compare #(
    parameter int MAX_STRINGS = 64,
    parameter int MAX_CHARS   = 255
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_char,
    input  wire logic [$clog2(MAX_STRINGS)-1:0] i_wr_str,
    input  wire logic [sqs_pkg::LEN_W-1:0]  i_wr_pos,
    input  wire logic [sqs_pkg::CHR_W-1:0]  i_wr_data,
    input  wire logic                       i_wr_len,
    input  wire logic [sqs_pkg::LEN_W-1:0]  i_wr_len_val,
    input  wire sqs_pkg::t_cmp_req          i_req,
    output sqs_pkg::t_cmp_rsp               o_rsp
);
    localparam int SW = $clog2(MAX_STRINGS);
    localparam int DEPTH = MAX_STRINGS * MAX_CHARS;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_ADDR, S_DATA} t_state;

    logic [sqs_pkg::CHR_W-1:0] r_mem [DEPTH];
    logic [sqs_pkg::LEN_W-1:0] r_len [MAX_STRINGS];
    logic [sqs_pkg::CHR_W-1:0] r_ca, r_cb;
    logic [AW-1:0] r_base_a, r_base_b;
    logic [sqs_pkg::LEN_W-1:0] r_la, r_lb, r_k;
    t_state r_state;
    logic r_done;
    sqs_pkg::t_cmp_res r_res;
    logic [AW-1:0] w_wr_addr, w_rd_a, w_rd_b;
    logic [sqs_pkg::LEN_W-1:0] w_min;
    logic w_fin;

    assign w_wr_addr = AW'(i_wr_str) * AW'(MAX_CHARS) + AW'(i_wr_pos);
    assign w_rd_a = r_base_a + AW'(r_k);
    assign w_rd_b = r_base_b + AW'(r_k);
    assign w_min = (r_la < r_lb) ? r_la : r_lb;
    assign w_fin = ((r_state == S_ADDR) && (r_k == w_min)) ||
                   ((r_state == S_DATA) && (r_ca != r_cb));

    always_ff @(posedge i_clk) begin
        if (i_wr_char) begin
            r_mem[w_wr_addr] <= i_wr_data;
        end
        if (i_wr_len) begin
            r_len[i_wr_str] <= i_wr_len_val;
        end
        r_ca <= r_mem[w_rd_a];
        r_cb <= r_mem[w_rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_res   <= sqs_pkg::CMP_EQ;
        end else begin
            r_done <= w_fin;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_la     <= r_len[i_req.a[SW-1:0]];
                        r_lb     <= r_len[i_req.b[SW-1:0]];
                        r_base_a <= AW'(i_req.a[SW-1:0]) * AW'(MAX_CHARS);
                        r_base_b <= AW'(i_req.b[SW-1:0]) * AW'(MAX_CHARS);
                        r_k      <= '0;
                        r_state  <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    if (r_k == w_min) begin
                        r_res   <= (r_la == r_lb) ? sqs_pkg::CMP_EQ :
                                   (r_la < r_lb) ? sqs_pkg::CMP_LT : sqs_pkg::CMP_GT;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    if (r_ca != r_cb) begin
                        r_res   <= (r_ca < r_cb) ? sqs_pkg::CMP_LT : sqs_pkg::CMP_GT;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    `ASSERT_NEXT(a_cmp_idle, i_clk, i_rst_n, o_rsp.done, !o_rsp.done,
        "compare done held two cycles")
    `ASSERT_IMPLY(a_cmp_start, i_clk, i_rst_n, i_req.start, r_state == S_IDLE,
        "compare started while busy")
endmodule
`default_nettype wire

@@ rtl/string_quicksort_engine.sv @@
// String sorter. Characters load at one transfer per cycle while the block is
// in load mode. The transfer that carries end_of_list starts a quicksort
// (last-element pivot, explicit range stack) in which every comparison uses
// the shared compare unit; the input stays stalled until every sorted
// index has been transferred out.
// Depends on sqs_pkg, sqs_compare and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module string_quicksort_engine #(
    parameter int MAX_STRINGS = 64,
    parameter int MAX_CHARS   = 255
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_string,
    input  wire logic       i_end_of_list,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [5:0]      o_string_index,
    output logic            o_last,
    output logic            o_overflow
);
    localparam int SW = $clog2(MAX_STRINGS);
    localparam int CW = SW + 1;
    localparam int IW = sqs_pkg::IDX_W;
    localparam logic signed [IW+1:0] P_ONE = (IW+2)'(1);

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_POP, S_RANGE, S_PIV, S_RDI, S_CMPI, S_WAITI,
        S_RDJ, S_CMPJ, S_WAITJ, S_TEST, S_SWP1, S_SWP2, S_SWP3, S_FIN1,
        S_FIN2, S_PUSH1, S_PUSH2, S_EMIT
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [sqs_pkg::LEN_W-1:0] r_pos;
    logic r_ovf;
    logic [IW-1:0] r_order [MAX_STRINGS];
    logic [2*IW-1:0] r_stack [64];
    logic [2*IW-1:0] r_top;
    logic [6:0] r_sp;
    logic signed [IW+1:0] r_lo, r_hi, r_i, r_j;
    logic [IW-1:0] r_piv, r_ord_q, r_oi;
    logic [CW-1:0] r_k;
    logic r_valid;
    logic [5:0] r_idx;
    logic r_last;

    sqs_pkg::t_cmp_req w_req;
    sqs_pkg::t_cmp_rsp w_rsp;
    logic w_acc, w_store, w_end;

    assign w_acc   = i_valid && !o_stall;
    assign w_store = w_acc && (r_count < CW'(MAX_STRINGS)) &&
                     (r_pos < sqs_pkg::LEN_W'(MAX_CHARS));
    assign w_end   = w_acc && (i_end_of_string || i_end_of_list) &&
                     (r_count < CW'(MAX_STRINGS));
    assign o_stall = (r_state != S_LOAD);

    sqs_compare #(.MAX_STRINGS(MAX_STRINGS), .MAX_CHARS(MAX_CHARS)) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_char   (w_store),
        .i_wr_str    (r_count[SW-1:0]),
        .i_wr_pos    (r_pos),
        .i_wr_data   (i_char_code),
        .i_wr_len    (w_end),
        .i_wr_len_val(w_store ? r_pos + 1'b1 : r_pos),
        .i_req       (w_req),
        .o_rsp       (w_rsp)
    );

    always_comb begin
        w_req.start = (r_state == S_CMPI) || (r_state == S_CMPJ);
        w_req.a = r_ord_q;
        w_req.b = r_piv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_pos   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_sp    <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (i_end_of_string || i_end_of_list) begin
                            r_pos <= '0;
                        end else if (w_store) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        if (!w_store) begin
                            r_ovf <= 1'b1;
                        end
                        if (w_end) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_end_of_list) begin
                            r_k     <= '0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (r_k == r_count) begin
                        r_sp <= 7'd1;
                        r_stack[0] <= {IW'(0), IW'(r_count - 1'b1)};
                        r_k <= '0;
                        r_state <= (r_count < CW'(2)) ? S_EMIT : S_POP;
                    end else begin
                        r_order[r_k[SW-1:0]] <= IW'(r_k);
                        r_k <= r_k + 1'b1;
                    end
                end
                S_POP: begin
                    if (r_sp == 7'd0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_top   <= r_stack[6'(r_sp - 7'd1)];
                        r_sp    <= r_sp - 7'd1;
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    if (r_top[2*IW-1:IW] >= r_top[IW-1:0]) begin
                        r_state <= S_POP;
                    end else begin
                        r_lo    <= (IW+2)'(r_top[2*IW-1:IW]);
                        r_hi    <= (IW+2)'(r_top[IW-1:0]);
                        r_i     <= (IW+2)'(r_top[2*IW-1:IW]);
                        r_j     <= (IW+2)'(r_top[IW-1:0]) - P_ONE;
                        r_ord_q <= r_order[r_top[SW-1:0]];
                        r_state <= S_PIV;
                    end
                end
                S_PIV: begin
                    r_piv   <= r_ord_q;
                    r_state <= S_RDI;
                end
                S_RDI: begin
                    if (r_i <= r_j) begin
                        r_ord_q <= r_order[r_i[SW-1:0]];
                        r_state <= S_CMPI;
                    end else begin
                        r_state <= S_RDJ;
                    end
                end
                S_CMPI: begin
                    r_state <= S_WAITI;
                end
                S_WAITI: begin
                    if (w_rsp.done) begin
                        if (w_rsp.res == sqs_pkg::CMP_GT) begin
                            r_i <= r_i + P_ONE;
                            r_state <= S_RDI;
                        end else begin
                            r_state <= S_RDJ;
                        end
                    end
                end
                S_RDJ: begin
                    if (r_j >= r_i) begin
                        r_ord_q <= r_order[r_j[SW-1:0]];
                        r_state <= S_CMPJ;
                    end else begin
                        r_state <= S_TEST;
                    end
                end
                S_CMPJ: begin
                    r_state <= S_WAITJ;
                end
                S_WAITJ: begin
                    if (w_rsp.done) begin
                        if (w_rsp.res == sqs_pkg::CMP_LT) begin
                            r_j <= r_j - P_ONE;
                            r_state <= S_RDJ;
                        end else begin
                            r_state <= S_TEST;
                        end
                    end
                end
                S_TEST: begin
                    r_ord_q <= r_order[r_i[SW-1:0]];
                    r_state <= (r_i >= r_j) ? S_FIN1 : S_SWP1;
                end
                S_SWP1: begin
                    r_oi    <= r_ord_q;
                    r_ord_q <= r_order[r_j[SW-1:0]];
                    r_state <= S_SWP2;
                end
                S_SWP2: begin
                    r_order[r_i[SW-1:0]] <= r_ord_q;
                    r_state <= S_SWP3;
                end
                S_SWP3: begin
                    r_order[r_j[SW-1:0]] <= r_oi;
                    r_i <= r_i + P_ONE;
                    r_j <= r_j - P_ONE;
                    r_state <= S_RDI;
                end
                S_FIN1: begin
                    r_order[r_i[SW-1:0]] <= r_piv;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_order[r_hi[SW-1:0]] <= r_ord_q;
                    r_state <= S_PUSH1;
                end
                S_PUSH1: begin
                    if ((r_i + P_ONE < r_hi) && (r_sp < 7'd64)) begin
                        r_stack[r_sp[5:0]] <= {IW'(r_i + P_ONE), IW'(r_hi)};
                        r_sp <= r_sp + 7'd1;
                    end
                    r_state <= S_PUSH2;
                end
                S_PUSH2: begin
                    if ((r_lo < r_i - P_ONE) && (r_sp < 7'd64)) begin
                        r_stack[r_sp[5:0]] <= {IW'(r_lo), IW'(r_i - P_ONE)};
                        r_sp <= r_sp + 7'd1;
                    end
                    r_state <= S_POP;
                end
                S_EMIT: begin
                    if (!r_valid || !i_stall) begin
                        if (r_k == r_count) begin
                            r_valid <= 1'b0;
                            r_count <= '0;
                            r_pos   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_valid <= 1'b1;
                            r_idx   <= 6'(r_order[r_k[SW-1:0]]);
                            r_last  <= (r_k + 1'b1 == r_count);
                            r_k     <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_string_index = r_idx;
    assign o_last         = r_last;
    assign o_overflow     = r_ovf;

    `ASSERT_IMPLY(a_out_only_emit, i_clk, i_rst_n, o_valid, r_state == S_EMIT,
        "result outside emit phase")
    `ASSERT_IMPLY(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_STRINGS),
        "string count past capacity")
    `ASSERT_IMPLY(a_stack_cap, i_clk, i_rst_n, 1'b1, r_sp <= 7'd64,
        "range stack past depth")
endmodule
`default_nettype wire
